### hw/rtl/mrc_pkg.sv
// Shared codes, event type and CRC helper for the Modbus RTU response checker.
`default_nettype none
package mrc_pkg;

  // input operations (carried on in_tuser)
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // result status (carried on out_tuser)
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TIMEOUT  = 2'd1;
  localparam logic [1:0] ST_CRC      = 2'd2;
  localparam logic [1:0] ST_MISMATCH = 2'd3;

  // end-of-transaction event kinds
  localparam logic [2:0] EV_OK       = 3'd0;
  localparam logic [2:0] EV_TIMEOUT  = 3'd1;
  localparam logic [2:0] EV_BADCRC   = 3'd2;
  localparam logic [2:0] EV_MISMATCH = 3'd3;
  localparam logic [2:0] EV_REFUSE   = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_SLAVE   = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_LIMIT   = 2'd2;

  localparam logic [7:0]  FUNC_READ  = 8'h03;
  localparam logic [7:0]  STREAK_MAX = 8'd250;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;

  typedef struct packed {
    logic       valid;
    logic [2:0] kind;
    logic       is_read;
    logic [4:0] regs;
  } evt_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/mrc_word_ram.sv
// Register word buffer: one write port, one registered read port.
`default_nettype none
module mrc_word_ram #(
  parameter int DEPTH = 16,
  parameter int W     = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### hw/rtl/mrc_frame.sv
// Frame collector: byte count, running CRC, header capture, word RAM writes, timeout and end event.
`default_nettype none
module mrc_frame import mrc_pkg::*; #(
  parameter int MAX_READ_REGS = 16,
  localparam int AW = (MAX_READ_REGS > 1) ? $clog2(MAX_READ_REGS) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          item_acc,
  input  wire logic [1:0]    op,
  input  wire logic [7:0]    expect_function,
  input  wire logic [4:0]    expect_regs,
  input  wire logic [7:0]    rx_byte,
  input  wire logic [7:0]    slave_address,
  input  wire logic [15:0]   timeout_ticks,
  input  wire logic          evt_ack,
  output evt_t               evt,
  output logic               ram_we,
  output logic [AW-1:0]      ram_waddr,
  output logic [15:0]        ram_wdata
);

  localparam int NMAX     = (MAX_READ_REGS < 31) ? MAX_READ_REGS : 31;
  localparam int LMAX     = (5 + 2 * NMAX > 8) ? 5 + 2 * NMAX : 8;
  localparam int BW       = $clog2(LMAX + 1);
  localparam int DATA_END = 3 + 2 * MAX_READ_REGS;

  logic          busy_r,  busy_nxt;
  logic [7:0]    fn_r,    fn_nxt;
  logic [4:0]    nregs_r, nregs_nxt;
  logic [BW-1:0] flen_r,  flen_nxt;
  logic [BW-1:0] seen_r,  seen_nxt;
  logic [15:0]   crc_r,   crc_nxt;
  logic [15:0]   idle_r,  idle_nxt;
  logic [7:0]    head0_r, head0_nxt;
  logic [7:0]    head1_r, head1_nxt;
  logic [7:0]    head2_r, head2_nxt;
  logic [7:0]    hi_r,    hi_nxt;
  evt_t          evt_r,   evt_nxt;

  logic [15:0]   crc_byte;
  logic [BW-1:0] seen_inc;
  logic [15:0]   idle_inc;
  logic          is_read;
  logic          bad_frame;
  logic          mismatch;

  always_comb begin
    crc_byte  = crc_feed(crc_r, rx_byte);
    seen_inc  = seen_r + BW'(1);
    idle_inc  = (idle_r != 16'hFFFF) ? idle_r + 16'd1 : idle_r;
    is_read   = (fn_r == FUNC_READ);
    bad_frame = (crc_byte != 16'd0) || (head0_r != slave_address);
    mismatch  = (head1_r != fn_r) || (is_read && (head2_r != {2'b00, nregs_r, 1'b0}));

    busy_nxt  = busy_r;
    fn_nxt    = fn_r;
    nregs_nxt = nregs_r;
    flen_nxt  = flen_r;
    seen_nxt  = seen_r;
    crc_nxt   = crc_r;
    idle_nxt  = idle_r;
    head0_nxt = head0_r;
    head1_nxt = head1_r;
    head2_nxt = head2_r;
    hi_nxt    = hi_r;
    evt_nxt   = evt_r;

    ram_we    = 1'b0;
    // data byte d = seen - 3; word d/2 is written on its odd byte
    ram_waddr = AW'((seen_r - BW'(3)) >> 1);
    ram_wdata = {hi_r, rx_byte};

    if (evt_ack) begin
      evt_nxt.valid = 1'b0;
    end

    if (item_acc) begin
      case (op)
        OP_START: begin
          busy_nxt = 1'b0;
          if ((expect_function == FUNC_READ) && (32'(expect_regs) > MAX_READ_REGS)) begin
            evt_nxt = '{valid: 1'b1, kind: EV_REFUSE, is_read: 1'b1, regs: expect_regs};
          end else begin
            fn_nxt    = expect_function;
            nregs_nxt = expect_regs;
            flen_nxt  = (expect_function == FUNC_READ) ?
                        BW'(5) + BW'({expect_regs, 1'b0}) : BW'(8);
            seen_nxt  = '0;
            crc_nxt   = CRC_INIT;
            idle_nxt  = 16'd0;
            busy_nxt  = 1'b1;
          end
        end
        OP_BYTE: begin
          if (busy_r) begin
            if (seen_r == BW'(0)) begin
              head0_nxt = rx_byte;
            end else if (seen_r == BW'(1)) begin
              head1_nxt = rx_byte;
            end else if (seen_r == BW'(2)) begin
              head2_nxt = rx_byte;
            end else if (32'(seen_r) < DATA_END) begin
              if (seen_r[0]) begin
                hi_nxt = rx_byte;
              end else begin
                ram_we = 1'b1;
              end
            end
            crc_nxt  = crc_byte;
            seen_nxt = seen_inc;
            idle_nxt = 16'd0;
            if (seen_inc >= flen_r) begin
              busy_nxt      = 1'b0;
              evt_nxt.valid   = 1'b1;
              evt_nxt.is_read = is_read;
              evt_nxt.regs    = nregs_r;
              if (bad_frame) begin
                evt_nxt.kind = EV_BADCRC;
              end else if (mismatch) begin
                evt_nxt.kind = EV_MISMATCH;
              end else begin
                evt_nxt.kind = EV_OK;
              end
            end
          end
        end
        OP_TICK: begin
          if (busy_r) begin
            idle_nxt = idle_inc;
            if (idle_inc >= timeout_ticks) begin
              busy_nxt = 1'b0;
              evt_nxt  = '{valid: 1'b1, kind: EV_TIMEOUT, is_read: is_read, regs: nregs_r};
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      fn_r    <= 8'd0;
      nregs_r <= 5'd0;
      flen_r  <= '0;
      seen_r  <= '0;
      crc_r   <= CRC_INIT;
      idle_r  <= 16'd0;
      evt_r   <= '0;
    end else begin
      busy_r  <= busy_nxt;
      fn_r    <= fn_nxt;
      nregs_r <= nregs_nxt;
      flen_r  <= flen_nxt;
      seen_r  <= seen_nxt;
      crc_r   <= crc_nxt;
      idle_r  <= idle_nxt;
      evt_r   <= evt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head0_r <= head0_nxt;
    head1_r <= head1_nxt;
    head2_r <= head2_nxt;
    hi_r    <= hi_nxt;
  end

  assign evt = evt_r;

endmodule
`default_nettype wire

### hw/rtl/modbus_rtu_response_checker.sv
// Top level: configuration, link statistics, result sequencing and output register.
//
//  channel   dir  handshake              payload
//  in_*      in   in_tvalid/in_tready    tuser: operation; tdata: function, regs, rx byte
//  out_*     out  out_tvalid/out_tready  tuser: status; tdata: index, word, counters, link
//  cfg_*     in   cfg_we                 cfg_index selects register, cfg_wdata value
//
// Bytes that do not end a frame and ticks are taken every cycle while no result is pending. The
// item that ends a transaction holds in_tready low while the result is formed; a good read of n
// words then streams them from the word RAM, one per cycle while out_tready allows, input held
// meanwhile. Reset (rst_n low, synchronous) clears control state and loads register defaults.
// A stalled output holds its item; the input also stalls while a result waits for the output slot.
`default_nettype none
module modbus_rtu_response_checker import mrc_pkg::*; #(
  parameter int MAX_READ_REGS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [7:0] expect_function, [12:8] expect_regs, [20:13] rx_byte
  input  wire logic [1:0]  in_tuser,   // [1:0] operation
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [3:0] reg_index, [19:4] reg_value, [27:20] fail_count,
                                       // [43:28] crc_errors, [44] link_ok
  output logic [1:0]       out_tuser,  // [1:0] status
  output logic             out_tlast,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  localparam int AW = (MAX_READ_REGS > 1) ? $clog2(MAX_READ_REGS) : 1;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic [7:0]  slave_r,  slave_nxt;
  logic [15:0] tmo_r,    tmo_nxt;
  logic [7:0]  limit_r,  limit_nxt;
  logic [7:0]  streak_r, streak_nxt;
  logic [15:0] crcerr_r, crcerr_nxt;
  logic        link_r,   link_nxt;
  logic        state_r,  state_nxt;
  logic [4:0]  cur_r,    cur_nxt;
  logic [4:0]  rdn_r,    rdn_nxt;

  logic        ovalid_r, ovalid_nxt;
  logic [1:0]  ostat_r,  ostat_nxt;
  logic [3:0]  oidx_r,   oidx_nxt;
  logic [15:0] oval_r,   oval_nxt;
  logic [7:0]  ofail_r,  ofail_nxt;
  logic [15:0] ocrc_r,   ocrc_nxt;
  logic        olink_r,  olink_nxt;
  logic        olast_r,  olast_nxt;

  evt_t          evt;
  logic          evt_ack;
  logic          in_acc;
  logic          out_free;
  logic [7:0]    streak_inc;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic          ram_re;
  logic [15:0]   ram_rdata;
  logic          single;
  logic          word_last;

  assign in_tready = (state_r == S_IDLE) && !evt.valid;
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !ovalid_r || out_tready;
  assign evt_ack   = (state_r == S_IDLE) && evt.valid && out_free;

  mrc_frame #(.MAX_READ_REGS(MAX_READ_REGS)) u_frame (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_acc        (in_acc),
    .op              (in_tuser),
    .expect_function (in_tdata[7:0]),
    .expect_regs     (in_tdata[12:8]),
    .rx_byte         (in_tdata[20:13]),
    .slave_address   (slave_r),
    .timeout_ticks   (tmo_r),
    .evt_ack         (evt_ack),
    .evt             (evt),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata)
  );

  mrc_word_ram #(.DEPTH(MAX_READ_REGS), .W(16)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (AW'(cur_nxt)),
    .rdata (ram_rdata)
  );

  always_comb begin
    slave_nxt = slave_r;
    tmo_nxt   = tmo_r;
    limit_nxt = limit_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_SLAVE:   slave_nxt = cfg_wdata[7:0];
        CFG_TIMEOUT: tmo_nxt   = cfg_wdata;
        CFG_LIMIT:   limit_nxt = cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    streak_inc = (streak_r < STREAK_MAX) ? streak_r + 8'd1 : streak_r;
    word_last  = ((cur_r + 5'd1) == rdn_r);

    streak_nxt = streak_r;
    crcerr_nxt = crcerr_r;
    link_nxt   = link_r;
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    rdn_nxt    = rdn_r;
    ram_re     = 1'b0;
    single     = 1'b0;

    ovalid_nxt = ovalid_r && !out_tready;
    ostat_nxt  = ostat_r;
    oidx_nxt   = oidx_r;
    oval_nxt   = oval_r;
    ofail_nxt  = ofail_r;
    ocrc_nxt   = ocrc_r;
    olink_nxt  = olink_r;
    olast_nxt  = olast_r;

    case (state_r)
      S_IDLE: begin
        if (evt_ack) begin
          case (evt.kind)
            EV_TIMEOUT: begin
              streak_nxt = streak_inc;
              if (evt.is_read) link_nxt = (streak_inc < limit_r);
              ostat_nxt = ST_TIMEOUT;
              single    = 1'b1;
            end
            EV_BADCRC: begin
              crcerr_nxt = crcerr_r + 16'd1;
              streak_nxt = streak_inc;
              if (evt.is_read) link_nxt = (streak_inc < limit_r);
              ostat_nxt = ST_CRC;
              single    = 1'b1;
            end
            EV_MISMATCH: begin
              streak_nxt = 8'd0;
              if (evt.is_read) link_nxt = (limit_r != 8'd0);
              ostat_nxt = ST_MISMATCH;
              single    = 1'b1;
            end
            EV_REFUSE: begin
              link_nxt  = (streak_r < limit_r);
              ostat_nxt = ST_MISMATCH;
              single    = 1'b1;
            end
            EV_OK: begin
              streak_nxt = 8'd0;
              if (evt.is_read) link_nxt = 1'b1;
              if (evt.is_read && (evt.regs != 5'd0)) begin
                // first word read now; the RAM output is registered into the output item in S_READ
                state_nxt = S_READ;
                cur_nxt   = 5'd0;
                rdn_nxt   = evt.regs;
                ram_re    = 1'b1;
              end else begin
                ostat_nxt = ST_OK;
                single    = 1'b1;
              end
            end
            default: ;
          endcase
          if (single) begin
            ovalid_nxt = 1'b1;
            oidx_nxt   = 4'd0;
            oval_nxt   = 16'd0;
            ofail_nxt  = streak_nxt;
            ocrc_nxt   = crcerr_nxt;
            olink_nxt  = link_nxt;
            olast_nxt  = 1'b1;
          end
        end
      end
      S_READ: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          ostat_nxt  = ST_OK;
          oidx_nxt   = cur_r[3:0];
          oval_nxt   = ram_rdata;
          ofail_nxt  = streak_r;
          ocrc_nxt   = crcerr_r;
          olink_nxt  = link_r;
          olast_nxt  = word_last;
          if (word_last) begin
            state_nxt = S_IDLE;
          end else begin
            cur_nxt = cur_r + 5'd1;
            ram_re  = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_r  <= 8'd1;
      tmo_r    <= 16'd200;
      limit_r  <= 8'd3;
      streak_r <= 8'd0;
      crcerr_r <= 16'd0;
      link_r   <= 1'b0;
      state_r  <= S_IDLE;
      cur_r    <= 5'd0;
      rdn_r    <= 5'd0;
      ovalid_r <= 1'b0;
    end else begin
      slave_r  <= slave_nxt;
      tmo_r    <= tmo_nxt;
      limit_r  <= limit_nxt;
      streak_r <= streak_nxt;
      crcerr_r <= crcerr_nxt;
      link_r   <= link_nxt;
      state_r  <= state_nxt;
      cur_r    <= cur_nxt;
      rdn_r    <= rdn_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ostat_r <= ostat_nxt;
    oidx_r  <= oidx_nxt;
    oval_r  <= oval_nxt;
    ofail_r <= ofail_nxt;
    ocrc_r  <= ocrc_nxt;
    olink_r <= olink_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tuser  = ostat_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {3'b000, olink_r, ocrc_r, ofail_r, oval_r, oidx_r};

endmodule
`default_nettype wire

### hw/rtl/mrc_checker.sv
// Port-level checks for the response checker, bound to the top level.
`default_nettype none
module mrc_checker import mrc_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata,
  input wire logic [1:0]  out_tuser,
  input wire logic        out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
                                  && $stable(out_tlast))
    else $error("output item changed while stalled");

  // failures are single items with no register word
  a_fail_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_OK) |-> out_tlast && (out_tdata[19:0] == 20'd0))
    else $error("failure item not single or carries a word");

  a_ok_streak: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_OK) |-> (out_tdata[27:20] == 8'd0))
    else $error("success item with nonzero failure streak");

  a_streak_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[27:20] <= STREAK_MAX))
    else $error("failure streak above saturation");

  // inside a word burst the input stays closed and the next word follows
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready ##1 out_tvalid)
    else $error("register word burst broken");

endmodule

bind modbus_rtu_response_checker mrc_checker u_mrc_checker (.*);
`default_nettype wire
